// ===== sv/msh_pkg.sv =====
// Shared types and constants for the MurmurHash2 32-bit hash block.
// No dependencies; the front, queue, back, top level and testbench import this package.
`default_nettype none

package msh_pkg;

  localparam logic [31:0] MUR_M      = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam int unsigned AV_SHIFT_A = 13;
  localparam int unsigned AV_SHIFT_B = 15;

  // Register index of the seed register (paddr bit 2 carries the index).
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FULL,
    OP_TAIL
  } op_kind_t;

  // One classified request travelling from the front to the back.
  typedef struct packed {
    op_kind_t    kind;
    logic        first;
    logic        last;
    logic [31:0] init;
    logic [31:0] key;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage : msh_pkg

`default_nettype wire

// ===== sv/msh_in_if.sv =====
// Input request channel of the hash block: valid/ready plus message word fields.
// No dependencies.
`default_nettype none

interface msh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        first_item;
  logic [31:0] msg_length;
  logic        last_item;

  modport source (
    output valid, data_word, valid_bytes, first_item, msg_length, last_item,
    input  ready
  );
  modport sink (
    input  valid, data_word, valid_bytes, first_item, msg_length, last_item,
    output ready
  );
endinterface : msh_in_if

`default_nettype wire

// ===== sv/msh_out_if.sv =====
// Result channel of the hash block: valid/ready plus the finished hash.
// No dependencies.
`default_nettype none

interface msh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input  valid, hash_value, output ready);
endinterface : msh_out_if

`default_nettype wire

// ===== sv/msh_front.sv =====
// Front end: accept requests, classify them and pre-mix full key words.
// Depends on msh_pkg and msh_in_if.
`default_nettype none

module msh_front
  import msh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  msh_in_if.sink          in_chan,
  input  wire logic [31:0] seed,
  input  wire fifo_stat_t fifo_stat,
  output logic            push,
  output op_t             push_op
);

  logic        s1_v_r, s2_v_r;
  logic        s1_ready, s2_ready;
  op_kind_t    s1_kind_r;
  logic        s1_first_r, s1_last_r;
  logic [31:0] s1_init_r, s1_word_r, s1_prod_r;
  op_t         s2_op_r;

  op_kind_t    kind_in;
  logic [31:0] masked_in;
  logic [31:0] mixed_k;
  logic [31:0] prod_in;

  assign s2_ready      = !s2_v_r || !fifo_stat.full;
  assign s1_ready      = !s1_v_r || s2_ready;
  assign in_chan.ready = s1_ready;
  assign push          = s2_v_r && !fifo_stat.full;
  assign push_op       = s2_op_r;

  // Classify by byte count; counts of four and above are full words.
  always_comb begin
    kind_in   = OP_NONE;
    masked_in = in_chan.data_word;
    if (in_chan.valid_bytes[2]) begin
      kind_in = OP_FULL;
    end else begin
      unique case (in_chan.valid_bytes[1:0])
        2'd0: begin
          kind_in   = OP_NONE;
          masked_in = '0;
        end
        2'd1: begin
          kind_in   = OP_TAIL;
          masked_in = {24'd0, in_chan.data_word[7:0]};
        end
        2'd2: begin
          kind_in   = OP_TAIL;
          masked_in = {16'd0, in_chan.data_word[15:0]};
        end
        default: begin
          kind_in   = OP_TAIL;
          masked_in = {8'd0, in_chan.data_word[23:0]};
        end
      endcase
    end
  end

  assign prod_in = in_chan.data_word * MUR_M;
  assign mixed_k = (s1_prod_r ^ (s1_prod_r >> MIX_SHIFT)) * MUR_M;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_chan.valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      s1_kind_r  <= kind_in;
      s1_first_r <= in_chan.first_item;
      s1_last_r  <= in_chan.last_item;
      s1_init_r  <= seed ^ in_chan.msg_length;
      s1_word_r  <= masked_in;
      s1_prod_r  <= prod_in;
    end
    if (s2_ready && s1_v_r) begin
      s2_op_r.kind  <= s1_kind_r;
      s2_op_r.first <= s1_first_r;
      s2_op_r.last  <= s1_last_r;
      s2_op_r.init  <= s1_init_r;
      s2_op_r.key   <= (s1_kind_r == OP_FULL) ? mixed_k : s1_word_r;
    end
  end

endmodule : msh_front

`default_nettype wire

// ===== sv/msh_fifo.sv =====
// Short request queue between the front and back halves of the hash block.
// Depends on msh_pkg. DEPTH must be a power of two, at least 2.
`default_nettype none

module msh_fifo
  import msh_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire op_t   push_op,
  input  wire logic  pop,
  output op_t        pop_op,
  output fifo_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  op_t           mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_op     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule : msh_fifo

`default_nettype wire

// ===== sv/msh_back.sv =====
// Back end: fold requests into the running hash, finish and emit the result.
// Depends on msh_pkg and msh_out_if.
`default_nettype none

module msh_back
  import msh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire fifo_stat_t fifo_stat,
  input  wire op_t        pop_op,
  output logic            pop,
  msh_out_if.source       out_chan
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_AVAL,
    ST_EMIT
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] m_r, m_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic [31:0] h_base;
  logic        out_free;

  assign out_free            = !out_valid_r || out_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.hash_value = out_hash_r;
  assign pop                 = (state_r == ST_RUN) && !fifo_stat.empty;
  assign h_base              = pop_op.first ? pop_op.init : h_r;

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_RUN: begin
        if (pop) begin
          unique case (pop_op.kind)
            OP_FULL: h_nxt = (h_base * MUR_M) ^ pop_op.key;
            OP_TAIL: h_nxt = (h_base ^ pop_op.key) * MUR_M;
            default: h_nxt = h_base;
          endcase
          if (pop_op.last) begin
            state_nxt = ST_AVAL;
          end
        end
      end
      ST_AVAL: begin
        m_nxt     = (h_r ^ (h_r >> AV_SHIFT_A)) * MUR_M;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = m_r ^ (m_r >> AV_SHIFT_B);
          state_nxt     = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r        <= m_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule : msh_back

`default_nettype wire

// ===== sv/murmur2_hash32.sv =====
// MurmurHash2 32-bit streaming hash. A last request passes two front stages,
// the queue, the fold step, the avalanche multiply and the output register
// before its hash shows on out_chan.valid. Throughput: one request per cycle
// for non-last words while the queue and the result side do not stall; each
// last request holds the fold loop for the two avalanche steps.
// Reset (rst_n low, synchronous): seed 0, running hash 0, queue and outputs empty.
`default_nettype none

module murmur2_hash32
  import msh_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  msh_in_if.sink           in_chan,
  msh_out_if.source        out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration: single seed register at byte address 0.
  logic [31:0] seed_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SEED) ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr && (paddr[2] == REG_SEED)) begin
      seed_r <= pwdata;
    end
  end

  // Front classifies and pre-mixes keys; the queue decouples it from the
  // hash-dependent fold loop in the back.
  logic       push, pop;
  op_t        push_op, pop_op;
  fifo_stat_t fifo_stat;

  msh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .seed      (seed_r),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_op   (push_op)
  );

  msh_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .stat    (fifo_stat)
  );

  msh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .pop_op    (pop_op),
    .pop       (pop),
    .out_chan  (out_chan)
  );

  // Never write a full queue or read an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fifo_stat.full && !pop))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && fifo_stat.empty))
    else $error("request queue underflow");

  // A seed write lands in the register on the next cycle.
  a_seed_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (paddr[2] == REG_SEED)) |=> (seed_r == $past(pwdata)))
    else $error("seed write lost");

endmodule : murmur2_hash32

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the murmur2_hash32 streaming hash block.
// Depends on msh_pkg, the msh_in_if / msh_out_if interfaces and the RTL top level.
`default_nettype none

module testbench;
  import msh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Seed register address: index in paddr bit 2, byte lanes below it.
  localparam logic [2:0] SEED_ADDR = {REG_SEED, 2'b00};
  // Extra wait after the last owed hash; hold this long before touching the seed.
  localparam int SETTLE_CYCLES = 24;
  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  localparam int PHASE_REQUESTS = 180;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        first;
    logic [31:0] length;
    logic        last;
    bit          typed;       // hash below is the known answer
    logic [31:0] hash;
  } dir_row_t;

  localparam int DIR_ROWS = 20;

  logic clk = 1'b0;
  logic rst_n;

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  msh_in_if  in_if ();
  msh_out_if out_if ();

  murmur2_hash32 u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Local copy of the block's state: the hash advances at every accepted request, the seed at each seed write.
  logic [31:0] model_seed;
  logic [31:0] model_hash;
  // Finished hashes still owed by the block, oldest first.
  logic [31:0] hash_due [$];
  logic [31:0] oldest_hash;

  int errors = 0;
  int requests_sent = 0;
  int hashes_seen = 0;
  int seeds_used = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  dir_row_t dir_tab [DIR_ROWS];

  // Key mixing of one full word: multiply, fold down the top byte, multiply.
  function automatic logic [31:0] mix_key(input logic [31:0] k);
    logic [31:0] m;
    m = k * MUR_M;
    m = m ^ (m >> MIX_SHIFT);
    m = m * MUR_M;
    return m;
  endfunction

  // Final avalanche applied on the last request of a message.
  function automatic logic [31:0] avalanche_hash(input logic [31:0] h);
    logic [31:0] a;
    a = h ^ (h >> AV_SHIFT_A);
    a = a * MUR_M;
    a = a ^ (a >> AV_SHIFT_B);
    return a;
  endfunction

  // Running hash after one request: seed on first, then absorb by byte count.
  function automatic logic [31:0] absorb_request(input logic [31:0] h_in,
                                                 input logic [31:0] seed,
                                                 input logic [31:0] word,
                                                 input logic [2:0]  nbytes,
                                                 input logic        first,
                                                 input logic [31:0] length);
    logic [31:0] h;
    logic [31:0] mask;
    h = first ? (seed ^ length) : h_in;
    if (nbytes >= 3'd4) begin
      // Oversized counts behave as a full word.
      h = (h * MUR_M) ^ mix_key(word);
    end else if (nbytes != 3'd0) begin
      // Tail bytes: drop the unused upper bytes, xor, multiply.
      mask = (32'd1 << (8 * nbytes)) - 32'd1;
      h = (h ^ (word & mask)) * MUR_M;
    end
    return h;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Drive one request, wait for it to be taken, then predict its outcome.
  task automatic send_request(input logic [31:0] word, input logic [2:0] nbytes,
                              input logic first, input logic [31:0] length,
                              input logic last, input bit typed,
                              input logic [31:0] typed_hash);
    int gap;
    gap = pick_gap(in_calm);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.data_word   <= word;
    in_if.valid_bytes <= nbytes;
    in_if.first_item  <= first;
    in_if.msg_length  <= length;
    in_if.last_item   <= last;
    do @(posedge clk); while (!in_if.ready);
    model_hash = absorb_request(model_hash, model_seed, word, nbytes, first, length);
    if (last) hash_due.push_back(typed ? typed_hash : avalanche_hash(model_hash));
    requests_sent++;
  endtask

  // Drop valid and wait until the block has nothing left in flight.
  task automatic settle_block();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (hash_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write then read back; the seed copy advances at the write.
  task automatic write_seed(input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    model_seed = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      $display("%0t: seed readback expected %h actual %h", $time, value, readback);
      errors++;
    end
    seeds_used++;
  endtask

  // Mostly well-formed messages of random content, with noise and broken
  // streams mixed in, until the request quota of this phase is used up.
  task automatic run_messages(input int quota);
    int stop_at;
    int len;
    int nfull;
    int ntail;
    int nitems;
    int r;
    int i;
    logic [31:0] len_field;
    logic [2:0]  nb;
    bit drop_last;
    stop_at = requests_sent + quota;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
      r = $urandom_range(0, 99);
      if (r < 82) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(0, 16);
        else if (r < 95) len = $urandom_range(17, 48);
        else len = $urandom_range(49, 128);
        len_field = ($urandom_range(0, 9) == 0) ? $urandom : len;
        drop_last = ($urandom_range(0, 19) == 0);
        nfull = len / 4;
        ntail = len % 4;
        nitems = nfull + ((ntail != 0 || len == 0) ? 1 : 0);
        for (i = 0; i < nitems; i++) begin
          nb = (i < nfull) ? 3'd4 : 3'(ntail);
          send_request($urandom, nb, i == 0, len_field,
                       (i == nitems - 1) && !drop_last, 1'b0, 32'h0);
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_request($urandom, 3'($urandom_range(0, 7)), 1'($urandom),
                       $urandom, 1'($urandom), 1'b0, 32'h0);
        end
      end
    end
  endtask

  // Result side: pop the oldest owed hash and compare.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      hashes_seen++;
      if (hash_due.size() == 0) begin
        $display("%0t: hash %h arrived with none expected", $time, out_if.hash_value);
        errors++;
      end else begin
        oldest_hash = hash_due.pop_front();
        if (out_if.hash_value !== oldest_hash) begin
          $display("%0t: hash_value expected %h actual %h", $time, oldest_hash,
                   out_if.hash_value);
          errors++;
        end
      end
    end
  end

  // Back-pressure on the result side: short stalls mostly, a few long ones,
  // and calm stretches with ready held high.
  initial begin : ready_gen
    int stall;
    int r;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 149) == 0) out_calm = !out_calm;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if (!out_calm && $urandom_range(0, 99) < 25) begin
        r = $urandom_range(0, 99);
        if (r < 75) stall = $urandom_range(1, 3);
        else if (r < 95) stall = $urandom_range(4, 12);
        else stall = $urandom_range(20, 50);
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Hang detector: count cycles with no handshake on either channel.
  initial begin : hang_watch
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_seq
    int k;
    // Drive every block input before the first edge.
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.data_word   = '0;
    in_if.valid_bytes = '0;
    in_if.first_item  = 1'b0;
    in_if.msg_length  = '0;
    in_if.last_item   = 1'b0;
    model_seed        = '0;
    model_hash        = '0;

    // Directed requests at the reset seed; typed hashes are the obvious zeros.
    dir_tab = '{
      // no first request after reset: hash of zero state is zero
      '{32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      // empty message, seed 0 and length 0: data ignored, hash zero
      '{32'hdead_beef, 3'd0, 1'b1, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{32'hffff_ffff, 3'd4, 1'b1, 32'h0000_0004, 1'b1, 1'b0, 32'h0},
      '{32'h0000_0000, 3'd4, 1'b1, 32'h0000_0004, 1'b1, 1'b0, 32'h0},
      // max length field, then a one-byte tail with junk above it
      '{32'h1234_5678, 3'd4, 1'b1, 32'hffff_ffff, 1'b0, 1'b0, 32'h0},
      '{32'hffff_ff9a, 3'd1, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
      '{32'ha5a5_a5a5, 3'd4, 1'b1, 32'h0000_0006, 1'b0, 1'b0, 32'h0},
      '{32'hffff_5a3c, 3'd2, 1'b0, 32'hffff_ffff, 1'b1, 1'b0, 32'h0},
      '{32'hff11_2233, 3'd3, 1'b1, 32'h0000_0003, 1'b1, 1'b0, 32'h0},
      // byte counts above four act as full words
      '{32'hcafe_f00d, 3'd5, 1'b1, 32'h0000_000c, 1'b0, 1'b0, 32'h0},
      '{32'h0bad_cafe, 3'd6, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h7777_7777, 3'd7, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
      // tail in mid-stream, a full word, an empty word, then a closing tail
      '{32'h0000_00ab, 3'd1, 1'b1, 32'h0000_0009, 1'b0, 1'b0, 32'h0},
      '{32'h89ab_cdef, 3'd4, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h0000_0000, 3'd0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{32'h00fe_dcba, 3'd3, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
      // continue from the pre-avalanche hash after a last request
      '{32'h1357_9bdf, 3'd4, 1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
      // first flag again in mid-message re-seeds
      '{32'h2468_ace0, 3'd4, 1'b1, 32'h0000_0008, 1'b0, 1'b0, 32'h0},
      '{32'h1111_1111, 3'd4, 1'b1, 32'h0000_0004, 1'b1, 1'b0, 32'h0},
      '{32'h8000_0001, 3'd4, 1'b1, 32'h8000_0000, 1'b1, 1'b0, 32'h0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIR_ROWS; k++) begin
      send_request(dir_tab[k].word, dir_tab[k].nbytes, dir_tab[k].first,
                   dir_tab[k].length, dir_tab[k].last, dir_tab[k].typed,
                   dir_tab[k].hash);
    end

    // Random phases, each under a new seed written while the block is idle.
    settle_block();
    write_seed(32'hffff_ffff);
    run_messages(PHASE_REQUESTS);
    settle_block();
    write_seed($urandom);
    run_messages(PHASE_REQUESTS);
    settle_block();
    write_seed(32'h0000_0001);
    run_messages(PHASE_REQUESTS);
    settle_block();
    write_seed(32'h8000_0000);
    run_messages(PHASE_REQUESTS);
    settle_block();
    write_seed($urandom);
    run_messages(PHASE_REQUESTS);
    settle_block();
    write_seed(32'h0000_0000);
    run_messages(PHASE_REQUESTS);

    // Drain: release valid, wait for owed hashes, then watch for strays.
    settle_block();

    $display("Run covered %0d requests and %0d finished hashes under %0d seed writes.",
             requests_sent, hashes_seen, seeds_used);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire
